// ===== rtl/phvg_pkg.sv =====
// phvg_pkg: shared widths, constants, register codes and gate structs
// for the pitch history vote and voice gate; no dependencies
package phvg_pkg;

  localparam int HistDepth = 20;
  localparam int FrameBins = 1024;

  localparam int BinW  = 10;
  localparam int MagW  = 24;
  localparam int NsW   = 11;
  localparam int WtW   = $clog2(FrameBins + 1);
  localparam int WSumW = 15;
  localparam int VSumW = 40;
  localparam int CntW  = 20;
  localparam int IdxW  = $clog2(HistDepth);
  localparam int ProdW = MagW + WSumW;
  localparam int CfgW  = 24;
  localparam int CfgIdxW = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [MagW-1:0] VolLimitRst   = MagW'(696);
  localparam logic [BinW-1:0] JumpBinsRst   = BinW'(10);
  localparam logic [CntW-1:0] MinVoiceRst   = CntW'(441);
  localparam logic [CntW-1:0] SilenceDropRst = CntW'(8820);

  typedef enum logic [CfgIdxW-1:0] {
    RegVolLimit,
    RegJumpBins,
    RegMinVoice,
    RegSilenceDrop
  } cfg_reg_e;

  typedef struct packed {
    logic [BinW-1:0] jump_bins;
    logic [CntW-1:0] min_voice;
    logic [CntW-1:0] silence_drop;
  } gate_cfg_t;

  typedef struct packed {
    logic            voiced;
    logic [BinW-1:0] start_bin;
    logic            onset;
    logic [CntW-1:0] duration;
  } gate_stat_t;

endpackage

// ===== rtl/phvg_gate.sv =====
// phvg_gate: silence/duration counters, voiced flag, base and reference bin
// uses phvg_pkg; updated once per frame with samples by the top level sequencer
module phvg_gate (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      upd_i,
  input  logic                      loud_i,
  input  logic [phvg_pkg::BinW-1:0] vbin_i,
  input  logic [phvg_pkg::WtW-1:0]  ns_i,
  input  phvg_pkg::gate_cfg_t       cfg_i,
  output phvg_pkg::gate_stat_t      stat_o
);

  logic [phvg_pkg::CntW-1:0] sil_q, dur_q;
  logic                      voiced_q, onset_q;
  logic [phvg_pkg::BinW-1:0] start_q, ref_q;

  logic [phvg_pkg::BinW-1:0] ref_sel, diff;
  logic [phvg_pkg::CntW-1:0] dur_base, dur_sat, sil_sat;
  logic [phvg_pkg::CntW:0]   dur_sum, sil_sum;
  logic                      jump;

  always_comb begin
    ref_sel  = voiced_q ? ref_q : vbin_i;
    diff     = (vbin_i >= ref_sel) ? (vbin_i - ref_sel) : (ref_sel - vbin_i);
    jump     = (diff >= cfg_i.jump_bins);
    // a new run or a jump restarts the duration before adding this frame
    dur_base = (voiced_q && !jump) ? dur_q : '0;
    dur_sum  = {1'b0, dur_base} + (phvg_pkg::CntW+1)'(ns_i);
    dur_sat  = dur_sum[phvg_pkg::CntW] ? phvg_pkg::CntMax : dur_sum[phvg_pkg::CntW-1:0];
    sil_sum  = {1'b0, sil_q} + (phvg_pkg::CntW+1)'(ns_i);
    sil_sat  = sil_sum[phvg_pkg::CntW] ? phvg_pkg::CntMax : sil_sum[phvg_pkg::CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sil_q    <= '0;
      dur_q    <= '0;
      voiced_q <= 1'b0;
      onset_q  <= 1'b0;
      start_q  <= '0;
      ref_q    <= '0;
    end else if (upd_i) begin
      if (!loud_i) begin
        sil_q   <= sil_sat;
        dur_q   <= '0;
        onset_q <= 1'b0;
        if (sil_sat > cfg_i.silence_drop) begin
          voiced_q <= 1'b0;
        end
      end else begin
        if (!voiced_q) begin
          start_q <= vbin_i;
          ref_q   <= vbin_i;
        end
        dur_q   <= dur_sat;
        onset_q <= jump;
        sil_q   <= '0;
        if (dur_sat > cfg_i.min_voice) begin
          voiced_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.voiced    = voiced_q;
  assign stat_o.start_bin = start_q;
  assign stat_o.onset     = onset_q;
  assign stat_o.duration  = dur_q;

endmodule

// ===== rtl/pitch_history_vote_voice_gate.sv =====
// pitch_history_vote_voice_gate: frame history, weighted bin vote, volume test
// uses phvg_pkg and phvg_gate
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  frame   | in_valid_i/in_ready_o, peak_bin, peak_magnitude,| in
//          | new_samples                                    |
//  result  | out_valid_o/out_ready_i, voice_bin .. duration | out
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i                | in
//
// a frame with samples passes these steps from its accepting edge to the result
// load: the per-entry weight lanes, the newest-first vote scan, the shared
// multiplier forming magnitude times weight, the limit product while the last
// sum lands, then compare, gate update and load.
// ready returns in the cycle after the load.
// a frame with zero samples is accepted and leaves everything alone.
// reset clears history, counters and config to defaults; a finished result
// waits in the output register while the next frame is processed, and the
// sequencer holds before loading only if that register is full and not taken.
module pitch_history_vote_voice_gate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [phvg_pkg::BinW-1:0]   peak_bin_i,
  input  logic [phvg_pkg::MagW-1:0]   peak_magnitude_i,
  input  logic [phvg_pkg::NsW-1:0]    new_samples_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [phvg_pkg::BinW-1:0]   voice_bin_o,
  output logic [phvg_pkg::VSumW-1:0]  volume_sum_o,
  output logic [phvg_pkg::WSumW-1:0]  weight_sum_o,
  output logic                        loud_o,
  output logic                        voice_active_o,
  output logic [phvg_pkg::BinW-1:0]   base_bin_o,
  output logic                        onset_o,
  output logic [phvg_pkg::CntW-1:0]   duration_count_o,
  input  logic                        cfg_we_i,
  input  logic [phvg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [phvg_pkg::CfgW-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle,
    StWacc,
    StPick,
    StVmac,
    StLmul,
    StCmp,
    StGate,
    StOut
  } state_e;

  localparam logic [phvg_pkg::IdxW-1:0] LastIdx = phvg_pkg::IdxW'(phvg_pkg::HistDepth - 1);

  // configuration
  logic [phvg_pkg::MagW-1:0] vol_limit_q;
  phvg_pkg::gate_cfg_t       gcfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_limit_q         <= phvg_pkg::VolLimitRst;
      gcfg_q.jump_bins    <= phvg_pkg::JumpBinsRst;
      gcfg_q.min_voice    <= phvg_pkg::MinVoiceRst;
      gcfg_q.silence_drop <= phvg_pkg::SilenceDropRst;
    end else if (cfg_we_i) begin
      unique case (phvg_pkg::cfg_reg_e'(cfg_idx_i))
        phvg_pkg::RegVolLimit:    vol_limit_q <= cfg_wdata_i[phvg_pkg::MagW-1:0];
        phvg_pkg::RegJumpBins:    gcfg_q.jump_bins <= cfg_wdata_i[phvg_pkg::BinW-1:0];
        phvg_pkg::RegMinVoice:    gcfg_q.min_voice <= cfg_wdata_i[phvg_pkg::CntW-1:0];
        phvg_pkg::RegSilenceDrop: gcfg_q.silence_drop <= cfg_wdata_i[phvg_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  state_e                     state_q;
  logic [phvg_pkg::IdxW-1:0]  idx_q;
  logic [phvg_pkg::BinW-1:0]  hist_bin_q [phvg_pkg::HistDepth];
  logic [phvg_pkg::MagW-1:0]  hist_mag_q [phvg_pkg::HistDepth];
  logic [phvg_pkg::WtW-1:0]   hist_wt_q  [phvg_pkg::HistDepth];
  logic [phvg_pkg::WSumW-1:0] acc_q      [phvg_pkg::HistDepth];
  logic [phvg_pkg::WSumW-1:0] best_w_q;
  logic [phvg_pkg::BinW-1:0]  vbin_q;
  logic [phvg_pkg::ProdW-1:0] prod_q;
  logic                       pv_q;
  logic [phvg_pkg::VSumW-1:0] vsum_q;
  logic                       loud_q;

  logic                       in_fire, take;
  logic [phvg_pkg::WtW-1:0]   ns_clamp;
  logic [phvg_pkg::MagW-1:0]  mul_a;
  logic [phvg_pkg::WSumW-1:0] mul_b;
  logic                       vmatch;
  logic                       gate_upd;
  phvg_pkg::gate_stat_t       gstat;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign take       = in_fire && (new_samples_i != '0);
  assign ns_clamp   = (new_samples_i > phvg_pkg::NsW'(phvg_pkg::FrameBins))
                      ? phvg_pkg::WtW'(phvg_pkg::FrameBins)
                      : phvg_pkg::WtW'(new_samples_i);

  // history shift line, newest at the top index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < phvg_pkg::HistDepth; k++) begin
        hist_bin_q[k] <= '0;
        hist_mag_q[k] <= '0;
        hist_wt_q[k]  <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < phvg_pkg::HistDepth - 1; k++) begin
        hist_bin_q[k] <= hist_bin_q[k+1];
        hist_mag_q[k] <= hist_mag_q[k+1];
        hist_wt_q[k]  <= hist_wt_q[k+1];
      end
      hist_bin_q[phvg_pkg::HistDepth-1] <= peak_bin_i;
      hist_mag_q[phvg_pkg::HistDepth-1] <= peak_magnitude_i;
      hist_wt_q[phvg_pkg::HistDepth-1]  <= ns_clamp;
    end
  end

  // weight lanes: each entry sums the weights of all entries with its bin
  always_ff @(posedge clk_i) begin
    if (state_q == StWacc) begin
      for (int k = 0; k < phvg_pkg::HistDepth; k++) begin
        acc_q[k] <= ((idx_q == '0) ? '0 : acc_q[k])
                  + ((hist_bin_q[k] == hist_bin_q[idx_q])
                     ? phvg_pkg::WSumW'(hist_wt_q[idx_q]) : '0);
      end
    end
  end

  // shared multiplier: magnitude times weight, then limit times best weight
  assign vmatch = (hist_bin_q[idx_q] == vbin_q);
  always_comb begin
    if (state_q == StLmul) begin
      mul_a = vol_limit_q;
      mul_b = best_w_q;
    end else begin
      mul_a = hist_mag_q[idx_q];
      mul_b = phvg_pkg::WSumW'(hist_wt_q[idx_q]);
    end
  end

  assign gate_upd = (state_q == StGate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      idx_q            <= '0;
      pv_q             <= 1'b0;
      out_valid_o      <= 1'b0;
      best_w_q         <= '0;
      vbin_q           <= '0;
      prod_q           <= '0;
      vsum_q           <= '0;
      loud_q           <= 1'b0;
      voice_bin_o      <= '0;
      volume_sum_o     <= '0;
      weight_sum_o     <= '0;
      loud_o           <= 1'b0;
      voice_active_o   <= 1'b0;
      base_bin_o       <= '0;
      onset_o          <= 1'b0;
      duration_count_o <= '0;
    end else begin
      // in StOut the load below decides the valid flag
      if (out_valid_o && out_ready_i && (state_q != StOut)) begin
        out_valid_o <= 1'b0;
      end
      if (pv_q) begin
        vsum_q <= vsum_q + phvg_pkg::VSumW'(prod_q);
      end
      unique case (state_q)
        StIdle: begin
          if (take) begin
            idx_q   <= '0;
            state_q <= StWacc;
          end
        end
        StWacc: begin
          if (idx_q == LastIdx) begin
            best_w_q <= '0;
            state_q  <= StPick;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StPick: begin
          // newest first, strict compare keeps the newest bin on ties
          if (acc_q[idx_q] > best_w_q) begin
            best_w_q <= acc_q[idx_q];
            vbin_q   <= hist_bin_q[idx_q];
          end
          if (idx_q == '0) begin
            vsum_q  <= '0;
            state_q <= StVmac;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        StVmac: begin
          prod_q <= vmatch ? (phvg_pkg::ProdW'(mul_a) * phvg_pkg::ProdW'(mul_b)) : '0;
          pv_q   <= 1'b1;
          if (idx_q == LastIdx) begin
            state_q <= StLmul;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StLmul: begin
          // last product is added this cycle while the limit product forms
          prod_q  <= phvg_pkg::ProdW'(mul_a) * phvg_pkg::ProdW'(mul_b);
          pv_q    <= 1'b0;
          state_q <= StCmp;
        end
        StCmp: begin
          loud_q  <= (vsum_q > phvg_pkg::VSumW'(prod_q));
          state_q <= StGate;
        end
        StGate: begin
          state_q <= StOut;
        end
        StOut: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o      <= 1'b1;
            voice_bin_o      <= vbin_q;
            volume_sum_o     <= vsum_q;
            weight_sum_o     <= best_w_q;
            loud_o           <= loud_q;
            voice_active_o   <= gstat.voiced;
            base_bin_o       <= gstat.start_bin;
            onset_o          <= gstat.onset;
            duration_count_o <= gstat.duration;
            idx_q            <= '0;
            state_q          <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  phvg_gate u_gate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (gate_upd),
    .loud_i (loud_q),
    .vbin_i (vbin_q),
    .ns_i   (hist_wt_q[phvg_pkg::HistDepth-1]),
    .cfg_i  (gcfg_q),
    .stat_o (gstat)
  );

`ifndef SYNTHESIS
  a_zero_frame_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (new_samples_i == '0)) |=> in_ready_o)
    else $error("frame with zero samples started processing");

  a_weight_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (best_w_q != '0))
    else $error("vote finished with zero winning weight");

  a_onset_needs_loud: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && onset_o |-> loud_o)
    else $error("onset flagged on a quiet frame");

  a_loud_needs_volume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loud_o |-> (volume_sum_o != '0))
    else $error("loud frame with zero volume sum");

  a_gate_before_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> $past(state_q == StGate) || $past(state_q == StOut))
    else $error("result load without gate update");
`endif

endmodule
